### hw/rtl/glos_pkg.sv
// ----------------------------------------------------------------------------
// glos_pkg
// Shared types and constants of the grid line-of-sight block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glos_pkg;

    // Field widths of the request and result items.
    localparam int COORD_W    = 24;
    localparam int MAP_ID_W   = 16;
    localparam int COL_W      = 10;
    localparam int DIM_W      = 11;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 8;

    // Bit offsets of the request fields inside s_tdata.
    localparam int OFS_MAP_ID  = 0;
    localparam int OFS_FROM_X  = OFS_MAP_ID + MAP_ID_W;
    localparam int OFS_FROM_Y  = OFS_FROM_X + COORD_W;
    localparam int OFS_TO_X    = OFS_FROM_Y + COORD_W;
    localparam int OFS_TO_Y    = OFS_TO_X + COORD_W;
    localparam int OFS_COL     = OFS_TO_Y + COORD_W;
    localparam int OFS_ROW     = OFS_COL + COL_W;
    localparam int OFS_BLOCKED = OFS_ROW + COL_W;

    // Request kinds carried in s_tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register reset values.
    localparam logic [MAP_ID_W-1:0] MAP_ID_RST     = 16'd0;
    localparam logic [DIM_W-1:0]    MAP_WIDTH_RST  = 11'd1000;
    localparam logic [DIM_W-1:0]    MAP_HEIGHT_RST = 11'd1000;
    localparam logic [COORD_W-1:0]  ORIGIN_RST     = 24'd0;
    localparam logic [SHIFT_W-1:0]  CELL_SHIFT_RST = 4'd8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_ID     = 3'd0,
        CFG_MAP_WIDTH  = 3'd1,
        CFG_MAP_HEIGHT = 3'd2,
        CFG_ORIGIN_X   = 3'd3,
        CFG_ORIGIN_Y   = 3'd4,
        CFG_CELL_SHIFT = 3'd5
    } glos_cfg_idx_t;

    // Coordinate handled by the shared world-to-cell unit.
    typedef enum logic [1:0] {
        CRD_FROM_X = 2'd0,
        CRD_FROM_Y = 2'd1,
        CRD_TO_X   = 2'd2,
        CRD_TO_Y   = 2'd3
    } glos_coord_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_CONV  = 7'b0000100,
        ST_DELTA = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_DONE  = 7'b1000000
    } glos_state_t;

    // Command to the cell map; at most one of clear, write and read is set.
    typedef struct packed {
        logic clear;
        logic write;
        logic read;
        logic bit_value;
    } glos_map_cmd_t;

endpackage

### hw/rtl/glos_cell_map.sv
// ----------------------------------------------------------------------------
// glos_cell_map
// Blocked-bit map stored as one memory row per grid row, with row clear,
// single-bit write and a registered row read followed by a column select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glos_cell_map
    import glos_pkg::*;
#(
    parameter int GRID_SIDE = 1024
)
(
    input  logic                         clk,
    input  glos_map_cmd_t                cmd,
    input  logic [$clog2(GRID_SIDE)-1:0] row,
    input  logic [$clog2(GRID_SIDE)-1:0] col,
    output logic                         rd_bit
);

    localparam int AW = $clog2(GRID_SIDE);

    logic [GRID_SIDE-1:0] mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] rd_word_reg;
    logic [AW-1:0]        rd_col_reg;

    // Row clear or single-bit update on the one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[row] <= '0;
        end
        else if (cmd.write)
        begin
            mem[row][col] <= cmd.bit_value;
        end
    end

    // Registered row read; the column is kept for the select that follows.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_word_reg <= mem[row];
            rd_col_reg  <= col;
        end
    end

    assign rd_bit = rd_word_reg[rd_col_reg];

endmodule

### hw/rtl/grid_line_of_sight.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight
// Line-of-sight test over a one-bit blocked-cell grid. A write request sets
// or clears one cell and is acknowledged through the done state, without a
// walk. A query request converts its two world points to cells with one
// shared subtract-and-shift unit, one coordinate at a time, forms the
// Bresenham deltas, then walks the line cell by cell, each cell needing a
// registered read of the map memory, and delivers its answer through the
// done state, without a walk when the map id does not match.
// The next request is taken while a result still waits on the master side.
// After reset the map is cleared one row per cycle, over all GRID_SIDE rows,
// during which no request is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_line_of_sight
    import glos_pkg::*;
#(
    parameter int GRID_SIDE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: map_id, from_x, from_y, to_x, to_y, cell_col,
    // cell_row, cell_blocked, zero fill.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode.
    input  logic                  s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: visible, zero fill.
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: answered_query.
    output logic                  m_tuser
);

    localparam int AW = $clog2(GRID_SIDE);
    localparam int IW = ((AW > COL_W) ? AW : COL_W) + 1;
    localparam int CW = COORD_W + 1;
    localparam int WW = COORD_W + 3;
    localparam int EW = COORD_W + 5;

    // Request fields.
    logic [MAP_ID_W-1:0] in_map_id;
    logic [COORD_W-1:0]  in_from_x;
    logic [COORD_W-1:0]  in_from_y;
    logic [COORD_W-1:0]  in_to_x;
    logic [COORD_W-1:0]  in_to_y;
    logic [COL_W-1:0]    in_col;
    logic [COL_W-1:0]    in_row;
    logic                in_blocked;

    assign in_map_id  = s_tdata[OFS_MAP_ID +: MAP_ID_W];
    assign in_from_x  = s_tdata[OFS_FROM_X +: COORD_W];
    assign in_from_y  = s_tdata[OFS_FROM_Y +: COORD_W];
    assign in_to_x    = s_tdata[OFS_TO_X +: COORD_W];
    assign in_to_y    = s_tdata[OFS_TO_Y +: COORD_W];
    assign in_col     = s_tdata[OFS_COL +: COL_W];
    assign in_row     = s_tdata[OFS_ROW +: COL_W];
    assign in_blocked = s_tdata[OFS_BLOCKED];

    // Configuration registers.
    logic [MAP_ID_W-1:0] map_id_reg;
    logic [DIM_W-1:0]    map_width_reg;
    logic [DIM_W-1:0]    map_height_reg;
    logic [COORD_W-1:0]  origin_x_reg;
    logic [COORD_W-1:0]  origin_y_reg;
    logic [SHIFT_W-1:0]  cell_shift_reg;

    // Sequencer and walk state.
    glos_state_t         state_reg;
    glos_coord_t         conv_sel_reg;
    logic [AW-1:0]       clr_row_reg;
    logic                query_reg;
    logic                visible_reg;
    logic                inb_reg;
    logic signed [WW-1:0] col_reg;
    logic signed [WW-1:0] row_reg;
    logic signed [WW-1:0] tgt_col_reg;
    logic signed [WW-1:0] tgt_row_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [EW-1:0] dx_reg;
    logic signed [EW-1:0] dy_reg;
    logic                sx_neg_reg;
    logic                sy_neg_reg;

    // Request payload held for the conversion steps.
    logic [COORD_W-1:0]  from_x_reg;
    logic [COORD_W-1:0]  from_y_reg;
    logic [COORD_W-1:0]  to_x_reg;
    logic [COORD_W-1:0]  to_y_reg;

    // Result register.
    logic                out_valid_reg;
    logic                out_query_reg;
    logic                out_visible_reg;

    logic                s_accept;
    logic                wr_in_range;
    logic                out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_query_reg;
    assign m_tdata   = {{(M_TDATA_W - 1){1'b0}}, out_visible_reg};

    // A write outside the stored grid is acknowledged but changes nothing.
    assign wr_in_range = (IW'(in_col) < IW'(GRID_SIDE)) && (IW'(in_row) < IW'(GRID_SIDE));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_id_reg     <= MAP_ID_RST;
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            origin_x_reg   <= ORIGIN_RST;
            origin_y_reg   <= ORIGIN_RST;
            cell_shift_reg <= CELL_SHIFT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (glos_cfg_idx_t'(cfg_index))
                CFG_MAP_ID:     map_id_reg     <= cfg_data[MAP_ID_W-1:0];
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[DIM_W-1:0];
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data[COORD_W-1:0];
                CFG_CELL_SHIFT: cell_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Shared world-to-cell unit: subtract the origin, then shift the
    // magnitude so that the quotient truncates toward zero.
    logic [COORD_W-1:0] conv_a;
    logic [COORD_W-1:0] conv_b;
    logic [CW-1:0]      conv_diff;
    logic [CW-1:0]      conv_mag;
    logic [CW-1:0]      conv_shr;
    logic [CW-1:0]      conv_cell;
    logic signed [WW-1:0] conv_cell_ext;

    always_comb
    begin
        unique case (conv_sel_reg)
            CRD_FROM_X:
            begin
                conv_a = from_x_reg;
                conv_b = origin_x_reg;
            end
            CRD_FROM_Y:
            begin
                conv_a = from_y_reg;
                conv_b = origin_y_reg;
            end
            CRD_TO_X:
            begin
                conv_a = to_x_reg;
                conv_b = origin_x_reg;
            end
            CRD_TO_Y:
            begin
                conv_a = to_y_reg;
                conv_b = origin_y_reg;
            end
            default:
            begin
                conv_a = from_x_reg;
                conv_b = origin_x_reg;
            end
        endcase
    end

    assign conv_diff     = {conv_a[COORD_W-1], conv_a} - {conv_b[COORD_W-1], conv_b};
    assign conv_mag      = conv_diff[CW-1] ? (~conv_diff + CW'(1)) : conv_diff;
    assign conv_shr      = conv_mag >> cell_shift_reg;
    assign conv_cell     = conv_diff[CW-1] ? (~conv_shr + CW'(1)) : conv_shr;
    assign conv_cell_ext = WW'($signed(conv_cell));

    // Line deltas from the start and end cells.
    logic signed [WW-1:0] delta_x;
    logic signed [WW-1:0] delta_y;
    logic signed [EW-1:0] abs_dx;
    logic signed [EW-1:0] abs_dy;

    assign delta_x = tgt_col_reg - col_reg;
    assign delta_y = tgt_row_reg - row_reg;
    assign abs_dx  = EW'(delta_x[WW-1] ? -delta_x : delta_x);
    assign abs_dy  = EW'(delta_y[WW-1] ? -delta_y : delta_y);

    // Grid bounds and the in-grid test of the current cell.
    logic [IW-1:0] w_lim;
    logic [IW-1:0] h_lim;
    logic          cur_inb;

    assign w_lim = (IW'(map_width_reg) < IW'(GRID_SIDE)) ? IW'(map_width_reg) : IW'(GRID_SIDE);
    assign h_lim = (IW'(map_height_reg) < IW'(GRID_SIDE)) ? IW'(map_height_reg)
                                                          : IW'(GRID_SIDE);
    assign cur_inb = !col_reg[WW-1] && !row_reg[WW-1]
                     && ($unsigned(col_reg) < WW'(w_lim))
                     && ($unsigned(row_reg) < WW'(h_lim));

    // One Bresenham step.
    logic signed [EW-1:0] e2;
    logic                 step_x;
    logic                 step_y;
    logic signed [EW-1:0] err_step;
    logic signed [WW-1:0] col_step;
    logic signed [WW-1:0] row_step;
    logic                 at_end;

    assign e2       = err_reg <<< 1;
    assign step_x   = e2 > -dy_reg;
    assign step_y   = e2 < dx_reg;
    assign err_step = err_reg - (step_x ? dy_reg : EW'(0)) + (step_y ? dx_reg : EW'(0));
    assign col_step = !step_x ? col_reg : (sx_neg_reg ? col_reg - WW'(1) : col_reg + WW'(1));
    assign row_step = !step_y ? row_reg : (sy_neg_reg ? row_reg - WW'(1) : row_reg + WW'(1));
    assign at_end   = (col_reg == tgt_col_reg) && (row_reg == tgt_row_reg);

    // Cell map commands.
    glos_map_cmd_t map_cmd;
    logic [AW-1:0] map_row;
    logic [AW-1:0] map_col;
    logic          map_bit;
    logic [IW-1:0] in_col_ext;
    logic [IW-1:0] in_row_ext;

    assign in_col_ext = IW'(in_col);
    assign in_row_ext = IW'(in_row);

    always_comb
    begin
        map_cmd.clear     = (state_reg == ST_CLEAR);
        map_cmd.write     = s_accept && (s_tuser == OP_WRITE) && wr_in_range;
        map_cmd.read      = (state_reg == ST_READ);
        map_cmd.bit_value = in_blocked;
        priority if (state_reg == ST_CLEAR)
        begin
            map_row = clr_row_reg;
            map_col = '0;
        end
        else if (state_reg == ST_READ)
        begin
            map_row = row_reg[AW-1:0];
            map_col = col_reg[AW-1:0];
        end
        else
        begin
            map_row = in_row_ext[AW-1:0];
            map_col = in_col_ext[AW-1:0];
        end
    end

    glos_cell_map #(
        .GRID_SIDE (GRID_SIDE)
    ) u_map (
        .clk    (clk),
        .cmd    (map_cmd),
        .row    (map_row),
        .col    (map_col),
        .rd_bit (map_bit)
    );

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            from_x_reg <= in_from_x;
            from_y_reg <= in_from_y;
            to_x_reg   <= in_to_x;
            to_y_reg   <= in_to_y;
        end
    end

    // Sequencer: clear pass, conversion, deltas and the cell walk.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            conv_sel_reg <= CRD_FROM_X;
            clr_row_reg  <= '0;
            query_reg    <= 1'b0;
            visible_reg  <= 1'b0;
            inb_reg      <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            tgt_col_reg  <= '0;
            tgt_row_reg  <= '0;
            err_reg      <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            sx_neg_reg   <= 1'b0;
            sy_neg_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + AW'(1);
                    if (clr_row_reg == AW'(GRID_SIDE - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        visible_reg <= 1'b0;
                        if (s_tuser == OP_WRITE)
                        begin
                            query_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else if (in_map_id != map_id_reg)
                        begin
                            query_reg <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            query_reg    <= 1'b1;
                            conv_sel_reg <= CRD_FROM_X;
                            state_reg    <= ST_CONV;
                        end
                    end
                end
                ST_CONV:
                begin
                    unique case (conv_sel_reg)
                        CRD_FROM_X: col_reg     <= conv_cell_ext;
                        CRD_FROM_Y: row_reg     <= conv_cell_ext;
                        CRD_TO_X:   tgt_col_reg <= conv_cell_ext;
                        CRD_TO_Y:   tgt_row_reg <= conv_cell_ext;
                        default:    ;
                    endcase
                    conv_sel_reg <= glos_coord_t'(2'(conv_sel_reg + 2'd1));
                    if (conv_sel_reg == CRD_TO_Y)
                    begin
                        state_reg <= ST_DELTA;
                    end
                end
                ST_DELTA:
                begin
                    dx_reg     <= abs_dx;
                    dy_reg     <= abs_dy;
                    err_reg    <= abs_dx - abs_dy;
                    sx_neg_reg <= !(col_reg < tgt_col_reg);
                    sy_neg_reg <= !(row_reg < tgt_row_reg);
                    state_reg  <= ST_READ;
                end
                ST_READ:
                begin
                    inb_reg   <= cur_inb;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!inb_reg || map_bit)
                    begin
                        visible_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                    else if (at_end)
                    begin
                        visible_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end
                    else
                    begin
                        err_reg   <= err_step;
                        col_reg   <= col_step;
                        row_reg   <= row_step;
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result register, loaded when the slot is free or being emptied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_query_reg   <= query_reg;
            out_visible_reg <= visible_reg;
        end
    end

`ifndef SYNTHESIS
    // The map never sees two commands in one cycle.
    a_map_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({map_cmd.clear, map_cmd.write, map_cmd.read}))
        else $error("cell map received more than one command");

    // A write request is answered without a walk.
    a_write_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_WRITE) |=> (state_reg == ST_DONE))
        else $error("write request did not go straight to the result");

    // A new result only appears after the sequencer has finished an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished request");

    // Each walk step moves the column by at most one cell.
    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && $past(state_reg) == ST_CHECK)
        |-> ((col_reg == $past(col_reg)) || (col_reg == $past(col_reg) + WW'(1))
             || (col_reg == $past(col_reg) - WW'(1))))
        else $error("walk moved more than one column");
`endif

endmodule
